[hw/rtl/lfu_pkg.sv]
// Shared types and constants for the LFU cache table.
package lfu_pkg;

  // Fixed field widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned PADDR_W = 3;

  // Register map: the register index is the word address bit
  localparam logic REG_CAPACITY = 1'b0;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Opcodes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Fixed data values
  localparam logic [DATA_W-1:0] COUNT_MAX  = '1;
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_PROMOTE,
    ST_DONE
  } seq_state_e;

  // Results of the shared compare unit
  typedef struct packed {
    logic match;   // stored key equals the item's key
    logic better;  // entry beats the current victim candidate
    logic aged;    // entry rank lies below the promotion limit
  } cmp_res_t;

endpackage

[hw/rtl/lfu_cmp.sv]
// Shared compare unit: key match, victim order and rank ageing test.
module lfu_cmp #(
  parameter int unsigned RANK_W = 5
) (
  input  logic [lfu_pkg::DATA_W-1:0] ent_key_i,
  input  logic [lfu_pkg::DATA_W-1:0] ref_key_i,
  input  logic [lfu_pkg::DATA_W-1:0] ent_cnt_i,
  input  logic [RANK_W-1:0]          ent_rank_i,
  input  logic                       best_set_i,
  input  logic [lfu_pkg::DATA_W-1:0] best_cnt_i,
  input  logic [RANK_W-1:0]          best_rank_i,
  input  logic [RANK_W-1:0]          limit_i,
  output lfu_pkg::cmp_res_t          res_o
);
  import lfu_pkg::*;

  // Lower count wins, older entry among equal counts
  always_comb begin
    res_o.match  = (ent_key_i == ref_key_i);
    res_o.better = !best_set_i || (ent_cnt_i < best_cnt_i) ||
                   ((ent_cnt_i == best_cnt_i) && (ent_rank_i > best_rank_i));
    res_o.aged   = (ent_rank_i < limit_i);
  end

endmodule

[hw/rtl/lfu_mem.sv]
// Entry memory: key, value, use count and recency rank per slot.
module lfu_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned IDX_W  = 4,
  parameter int unsigned RANK_W = 5
) (
  input  logic                       clk_i,
  input  logic                       re_i,
  input  logic [IDX_W-1:0]           raddr_i,
  input  logic                       we_i,
  input  logic [IDX_W-1:0]           waddr_i,
  input  logic [lfu_pkg::DATA_W-1:0] wkey_i,
  input  logic [lfu_pkg::DATA_W-1:0] wval_i,
  input  logic [lfu_pkg::DATA_W-1:0] wcnt_i,
  input  logic [RANK_W-1:0]          wrank_i,
  output logic [lfu_pkg::DATA_W-1:0] rkey_o,
  output logic [lfu_pkg::DATA_W-1:0] rval_o,
  output logic [lfu_pkg::DATA_W-1:0] rcnt_o,
  output logic [RANK_W-1:0]          rrank_o
);
  import lfu_pkg::*;

  logic [DATA_W-1:0] key_mem  [DEPTH];
  logic [DATA_W-1:0] val_mem  [DEPTH];
  logic [DATA_W-1:0] cnt_mem  [DEPTH];
  logic [RANK_W-1:0] rank_mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i]  <= wkey_i;
      val_mem[waddr_i]  <= wval_i;
      cnt_mem[waddr_i]  <= wcnt_i;
      rank_mem[waddr_i] <= wrank_i;
    end
  end

  // Registered read of one entry
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rkey_o  <= key_mem[raddr_i];
      rval_o  <= val_mem[raddr_i];
      rcnt_o  <= cnt_mem[raddr_i];
      rrank_o <= rank_mem[raddr_i];
    end
  end

endmodule

[hw/rtl/lfu_seq.sv]
// Sequencer: scan pass, replacement decision and promotion pass over the entries.
module lfu_seq #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [lfu_pkg::CAP_W-1:0]  capacity_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       opcode_i,
  input  logic [lfu_pkg::DATA_W-1:0] key_i,
  input  logic [lfu_pkg::DATA_W-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       hit_o,
  output logic [lfu_pkg::DATA_W-1:0] read_value_o
);
  import lfu_pkg::*;

  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned RANK_W = CNT_W;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DEPTH);

  seq_state_e state_q, state_d;

  // Sweep counter and read pipeline
  logic [CNT_W-1:0] cnt_q;
  logic             pend_q;
  logic [IDX_W-1:0] pidx_q;
  logic             last;

  // Item registers
  logic              op_q;
  logic [DATA_W-1:0] key_q, val_q;

  // Scan trackers
  logic              hit_q, free_set_q, vic_set_q;
  logic [IDX_W-1:0]  fidx_q, free_q, vic_q;
  logic [DATA_W-1:0] fval_q, vcnt_q;
  logic [RANK_W-1:0] frank_q, vrank_q;

  // Decision registers
  logic [IDX_W-1:0]  slot_q;
  logic [RANK_W-1:0] old_q;
  logic              ins_q;

  // Table state
  logic [DEPTH-1:0]  valid_q;
  logic [CNT_W-1:0]  occ_q;

  // Output register
  logic              out_valid_q, out_hit_q;
  logic [DATA_W-1:0] out_rd_q;

  // Memory ports
  logic              mem_re, mem_we;
  logic [DATA_W-1:0] rkey, rval, rcnt;
  logic [RANK_W-1:0] rrank;
  logic [DATA_W-1:0] wkey, wval, wcnt;
  logic [RANK_W-1:0] wrank;

  // Decision terms
  logic     room, do_touch, do_insert, do_evict, do_prom, accept, emit, is_slot, ent_vld;
  cmp_res_t cres;

  assign last    = (cnt_q == LAST);
  assign accept  = in_valid_i && in_ready_o;
  assign ent_vld = valid_q[pidx_q];
  assign is_slot = (pidx_q == slot_q);

  lfu_mem #(
    .DEPTH  (DEPTH),
    .IDX_W  (IDX_W),
    .RANK_W (RANK_W)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .we_i    (mem_we),
    .waddr_i (pidx_q),
    .wkey_i  (wkey),
    .wval_i  (wval),
    .wcnt_i  (wcnt),
    .wrank_i (wrank),
    .rkey_o  (rkey),
    .rval_o  (rval),
    .rcnt_o  (rcnt),
    .rrank_o (rrank)
  );

  lfu_cmp #(
    .RANK_W (RANK_W)
  ) u_cmp (
    .ent_key_i   (rkey),
    .ref_key_i   (key_q),
    .ent_cnt_i   (rcnt),
    .ent_rank_i  (rrank),
    .best_set_i  (vic_set_q),
    .best_cnt_i  (vcnt_q),
    .best_rank_i (vrank_q),
    .limit_i     (old_q),
    .res_o       (cres)
  );

  // Replacement decision from the scan results
  always_comb begin
    room      = (32'(occ_q) < 32'(capacity_i)) && (occ_q < LAST);
    do_touch  = hit_q;
    do_insert = !hit_q && (op_q == OP_PUT) && (capacity_i != '0) && room;
    do_evict  = !hit_q && (op_q == OP_PUT) && (capacity_i != '0) && !room && vic_set_q;
    do_prom   = do_touch || do_insert || do_evict;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:    if (last) state_d = ST_DECIDE;
      ST_DECIDE:  state_d = do_prom ? ST_PROMOTE : ST_DONE;
      ST_PROMOTE: if (last) state_d = ST_DONE;
      ST_DONE:    if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      ST_IDLE:    in_ready_o = 1'b1;
      ST_SCAN:    mem_re = !last;
      ST_DECIDE:  ;
      ST_PROMOTE: begin
        mem_re = !last;
        mem_we = pend_q;
      end
      ST_DONE:    emit = !out_valid_q || out_ready_i;
      default:    ;
    endcase
  end

  // Write-back data: the chosen slot takes the item and rank zero, entries ranked below its old rank age by one
  always_comb begin
    wkey  = (is_slot && ins_q) ? key_q : rkey;
    wval  = (is_slot && (op_q == OP_PUT)) ? val_q : rval;
    wcnt  = rcnt;
    wrank = rrank;
    if (is_slot) begin
      wrank = '0;
      if (ins_q) begin
        wcnt = DATA_W'(1);
      end else if (rcnt != COUNT_MAX) begin
        wcnt = rcnt + DATA_W'(1);
      end
    end else if (ent_vld && cres.aged) begin
      wrank = rrank + RANK_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_set_q  <= 1'b0;
      vic_set_q   <= 1'b0;
      ins_q       <= 1'b0;
      valid_q     <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= mem_re;
      // hold the sweep counter at its end, restart it for each pass
      if (accept || (state_q == ST_DECIDE)) begin
        cnt_q <= '0;
      end else if (mem_re) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (accept) begin
        hit_q      <= 1'b0;
        free_set_q <= 1'b0;
        vic_set_q  <= 1'b0;
      end else if ((state_q == ST_SCAN) && pend_q) begin
        if (ent_vld && cres.match && !hit_q) hit_q <= 1'b1;
        if (!ent_vld) free_set_q <= 1'b1;
        if (ent_vld && cres.better) vic_set_q <= 1'b1;
      end
      if (state_q == ST_DECIDE) begin
        ins_q <= do_insert || do_evict;
        if (do_insert) begin
          valid_q[free_q] <= 1'b1;
          occ_q           <= occ_q + CNT_W'(1);
        end
      end
      // drop the result once taken, load the next one
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pidx_q <= cnt_q[IDX_W-1:0];
    if (accept) begin
      op_q  <= opcode_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    if ((state_q == ST_SCAN) && pend_q) begin
      if (ent_vld && cres.match && !hit_q) begin
        fidx_q  <= pidx_q;
        fval_q  <= rval;
        frank_q <= rrank;
      end
      if (!ent_vld && !free_set_q) free_q <= pidx_q;
      if (ent_vld && cres.better) begin
        vic_q   <= pidx_q;
        vcnt_q  <= rcnt;
        vrank_q <= rrank;
      end
    end
    if (state_q == ST_DECIDE) begin
      if (do_touch) begin
        slot_q <= fidx_q;
        old_q  <= frank_q;
      end else if (do_insert) begin
        slot_q <= free_q;
        old_q  <= occ_q + CNT_W'(1);
      end else begin
        slot_q <= vic_q;
        old_q  <= vrank_q;
      end
    end
    if (emit) begin
      out_hit_q <= hit_q;
      if (op_q == OP_PUT) begin
        out_rd_q <= PUT_VALUE;
      end else begin
        out_rd_q <= hit_q ? fval_q : MISS_VALUE;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign read_value_o = out_rd_q;

endmodule

[hw/rtl/lfu_cache_table.sv]
// Top level of the LFU cache table: register port and item sequencer.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, opcode_i, key_i,  | in
//          | value_i                                   |
//  out     | out_valid_o, out_ready_i, hit_o,          | out
//          | read_value_o                              |
//  cfg     | psel, penable, pwrite, paddr, pwdata,     | in / out
//          | prdata, pready                            |
//
// An item whose result updates an entry takes two sweeps through the entry
// memory, a scan pass and a promotion pass; a get miss or a put that stores
// nothing takes the scan pass only. Each sweep reads one entry per cycle on
// the memory's single read port. One item is in work at a time.
// Reset clears the valid bits and occupancy at once, with no clearing pass;
// capacity resets to 16. A stalled result holds in the output register while
// the next item is already accepted.
module lfu_cache_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic signed [31:0]          key_i,
  input  logic signed [31:0]          value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic signed [31:0]          read_value_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfu_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lfu_pkg::*;

  logic [CAP_W-1:0]  cap_q;
  logic [DATA_W-1:0] rd_value;
  logic              reg_sel;

  assign reg_sel = (paddr[PADDR_W-1] == REG_CAPACITY);
  assign pready  = 1'b1;

  // Capacity register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // Register read-back
  always_comb begin
    prdata = '0;
    if (reg_sel) prdata = {{(32-CAP_W){1'b0}}, cap_q};
  end

  lfu_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .capacity_i   (cap_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .read_value_o (rd_value)
  );

  assign read_value_o = rd_value;

endmodule
